>>> src/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and constants for the sorted key set: widths, operation kinds,
// result status codes and the sequencer states.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int KEY_W          = 32;
    localparam int KIND_W         = 1;
    localparam int STATUS_W       = 3;
    localparam int COUNT_OUT_W    = 5;
    localparam int CAPACITY_DEFAULT = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } sks_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INSERTED = 3'd0,
        STATUS_EXISTS   = 3'd1,
        STATUS_REMOVED  = 3'd2,
        STATUS_EMPTY    = 3'd3,
        STATUS_MISSING  = 3'd4,
        STATUS_FULL     = 3'd5
    } sks_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } sks_state_t;

endpackage

>>> src/sks_ifs.sv
// ----------------------------------------------------------------------------
// sks_ifs
// Valid/ready channels of the sorted key set: the operation request and the
// operation result.
// ----------------------------------------------------------------------------
interface sks_req_if;
    logic                            valid;
    logic                            ready;
    logic [sks_pkg::KIND_W-1:0]      kind;
    logic signed [sks_pkg::KEY_W-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface sks_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sks_pkg::STATUS_W-1:0]        status;
    logic signed [sks_pkg::KEY_W-1:0]    key_out;
    logic [sks_pkg::COUNT_OUT_W-1:0]     entry_count;

    modport source (output valid, output status, output key_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input key_out, input entry_count,
                    output ready);
endinterface

>>> src/sorted_key_set_top.sv
// ----------------------------------------------------------------------------
// sorted_key_set_top
// Bounded set of distinct signed keys held in ascending order in a key memory.
// ----------------------------------------------------------------------------
// One operation at a time: req is ready only while the sequencer is idle.
// An operation scans the key memory from the bottom to find the first key not
// below the request key, then moves the entries above that point up (insert)
// or down (remove) one cell at a time. Every memory read goes through the
// single read port with registered data, so each probed entry passes through
// a read state and a compare state, and each moved entry through a read state
// and a write state. The result sits in an output register, so a pending
// result does not keep the next request from being taken; a result still
// pending when the next operation finishes holds the sequencer until it is
// taken. entry_count shows the low five bits of the count. No clearing pass
// is needed after reset.
// ----------------------------------------------------------------------------
module sorted_key_set_top #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    sks_req_if.sink       req,
    sks_rsp_if.source     rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W = sks_pkg::KEY_W;

    sks_pkg::sks_state_t  state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic                 found_reg, found_next;
    sks_pkg::sks_kind_t   kind_reg, kind_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    sks_pkg::sks_status_t status_reg, status_next;

    logic                 out_valid_reg, out_valid_next;
    sks_pkg::sks_status_t out_status_reg, out_status_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic [CNT_W-1:0]     out_count_reg, out_count_next;
    logic [CNT_W+4:0]     out_count_wide;

    // key memory, one write port and one registered read port
    logic signed [KEY_W-1:0] key_mem [CAPACITY];
    logic signed [KEY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic signed [KEY_W-1:0] mem_wdata;

    logic [CNT_W-1:0]     idx_inc;
    logic [CNT_W-1:0]     idx_dec;
    logic                 rd_less;
    logic                 rd_equal;
    logic                 out_load;

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);
    // the shared compare unit
    assign rd_less  = rd_data_reg < key_reg;
    assign rd_equal = rd_data_reg == key_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sks_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        found_reg      <= found_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_count_next  = out_count_reg;
        rd_addr         = idx_reg[IDX_W-1:0];
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[IDX_W-1:0];
        mem_wdata       = rd_data_reg;
        out_load        = 1'b0;
        req.ready       = 1'b0;

        case (state_reg)
            sks_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kind_next  = sks_pkg::sks_kind_t'(req.kind);
                    key_next   = req.key;
                    idx_next   = '0;
                    state_next = sks_pkg::ST_SCAN_RD;
                end
            end

            sks_pkg::ST_SCAN_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    pos_next   = idx_reg;
                    found_next = 1'b0;
                    state_next = sks_pkg::ST_DECIDE;
                end
                else
                begin
                    state_next = sks_pkg::ST_SCAN_CMP;
                end
            end

            sks_pkg::ST_SCAN_CMP:
            begin
                if (rd_less)
                begin
                    idx_next   = idx_inc;
                    state_next = sks_pkg::ST_SCAN_RD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    found_next = rd_equal;
                    state_next = sks_pkg::ST_DECIDE;
                end
            end

            sks_pkg::ST_DECIDE:
            begin
                state_next = sks_pkg::ST_FINISH;
                if (kind_reg == sks_pkg::KIND_INSERT)
                begin
                    if (found_reg)
                    begin
                        status_next = sks_pkg::STATUS_EXISTS;
                    end
                    else if (count_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = sks_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        idx_next   = count_reg;
                        state_next = sks_pkg::ST_SHIFT_RD;
                    end
                end
                else
                begin
                    if (count_reg == '0)
                    begin
                        status_next = sks_pkg::STATUS_EMPTY;
                    end
                    else if (!found_reg)
                    begin
                        status_next = sks_pkg::STATUS_MISSING;
                    end
                    else
                    begin
                        idx_next   = pos_reg;
                        state_next = sks_pkg::ST_SHIFT_RD;
                    end
                end
            end

            sks_pkg::ST_SHIFT_RD:
            begin
                if (kind_reg == sks_pkg::KIND_INSERT)
                begin
                    if (idx_reg == pos_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = pos_reg[IDX_W-1:0];
                        mem_wdata   = key_reg;
                        count_next  = count_reg + CNT_W'(1);
                        status_next = sks_pkg::STATUS_INSERTED;
                        state_next  = sks_pkg::ST_FINISH;
                    end
                    else
                    begin
                        rd_addr    = idx_dec[IDX_W-1:0];
                        state_next = sks_pkg::ST_SHIFT_WR;
                    end
                end
                else
                begin
                    if (idx_inc >= count_reg)
                    begin
                        count_next  = count_reg - CNT_W'(1);
                        status_next = sks_pkg::STATUS_REMOVED;
                        state_next  = sks_pkg::ST_FINISH;
                    end
                    else
                    begin
                        rd_addr    = idx_inc[IDX_W-1:0];
                        state_next = sks_pkg::ST_SHIFT_WR;
                    end
                end
            end

            sks_pkg::ST_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                if (kind_reg == sks_pkg::KIND_INSERT)
                begin
                    idx_next = idx_dec;
                end
                else
                begin
                    idx_next = idx_inc;
                end
                state_next = sks_pkg::ST_SHIFT_RD;
            end

            sks_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load        = 1'b1;
                    out_status_next = status_reg;
                    out_key_next    = key_reg;
                    out_count_next  = count_reg;
                    state_next      = sks_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sks_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_load | (out_valid_reg & ~rsp.ready);
    end

    assign out_count_wide  = {5'd0, out_count_reg};
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.entry_count = out_count_wide[4:0];

    // count stays within the table
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // memory is written only while moving entries or placing a key
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == sks_pkg::ST_SHIFT_RD || state_reg == sks_pkg::ST_SHIFT_WR))
        else $error("key memory written outside a shift");

    // scan never runs past the held keys
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sks_pkg::ST_SCAN_RD || state_reg == sks_pkg::ST_SCAN_CMP)
        |-> idx_reg <= count_reg)
        else $error("scan index beyond count");

    // a new result only follows the finish state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sks_pkg::ST_FINISH))
        else $error("result raised outside finish");

    // a shift write always lands inside the table
    a_shift_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sks_pkg::ST_SHIFT_WR) |-> idx_reg < CNT_W'(CAPACITY))
        else $error("shift write index out of range");

endmodule

>>> test/sks_checker.sv
// ----------------------------------------------------------------------------
// sks_checker
// Watches the request and result channels of the sorted key set. It keeps its
// own copy of the ordered key table, works out the result of every accepted
// request, and compares each accepted result field by field with the oldest
// expected one. It reports failures and how many results are still due.
// ----------------------------------------------------------------------------
module sks_checker #(
    parameter int CAPACITY = sks_pkg::CAPACITY_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    sks_req_if          req,
    sks_rsp_if          rsp,
    output int unsigned fail_count,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        sks_pkg::sks_status_t                  status;
        logic signed [sks_pkg::KEY_W-1:0]      key;
        logic [sks_pkg::COUNT_OUT_W-1:0]       count;
    } set_result_t;

    logic signed [sks_pkg::KEY_W-1:0] table_keys [CAPACITY];
    int unsigned                      table_size;
    set_result_t                      due_results [$];

    // updates the shadow table and returns the result the block should give
    function automatic set_result_t apply_op(input sks_pkg::sks_kind_t kind,
                                             input logic signed [sks_pkg::KEY_W-1:0] k);
        int unsigned pos;
        int unsigned j;
        set_result_t r;
        r.key = k;
        pos = 0;
        while (pos < table_size && table_keys[pos] < k)
            pos++;
        if (kind == sks_pkg::KIND_INSERT)
        begin
            // a duplicate wins over a full table
            if (pos < table_size && table_keys[pos] == k)
                r.status = sks_pkg::STATUS_EXISTS;
            else if (table_size >= CAPACITY)
                r.status = sks_pkg::STATUS_FULL;
            else
            begin
                for (j = table_size; j > pos; j--)
                    table_keys[j] = table_keys[j-1];
                table_keys[pos] = k;
                table_size++;
                r.status = sks_pkg::STATUS_INSERTED;
            end
        end
        else
        begin
            if (table_size == 0)
                r.status = sks_pkg::STATUS_EMPTY;
            else if (pos >= table_size || table_keys[pos] != k)
                r.status = sks_pkg::STATUS_MISSING;
            else
            begin
                for (j = pos; j + 1 < table_size; j++)
                    table_keys[j] = table_keys[j+1];
                table_size--;
                r.status = sks_pkg::STATUS_REMOVED;
            end
        end
        r.count = table_size[sks_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t exp_r;
        if (!rst_n)
        begin
            table_size = 0;
            due_results.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (req.valid === 1'b1 && req.ready === 1'b1)
                due_results.push_back(apply_op(sks_pkg::sks_kind_t'(req.kind), req.key));
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result status=%0d key=%0d count=%0d",
                                 $realtime, rsp.status, rsp.key_out, rsp.entry_count);
                end
                else
                begin
                    exp_r = due_results.pop_front();
                    if (rsp.status !== exp_r.status || rsp.key_out !== exp_r.key ||
                        rsp.entry_count !== exp_r.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result mismatch: expected status=%0d key=%0d ",
                                      "count=%0d, got status=%0d key=%0d count=%0d"},
                                     $realtime, exp_r.status, exp_r.key, exp_r.count,
                                     rsp.status, rsp.key_out, rsp.entry_count);
                    end
                end
            end
            outstanding = due_results.size();
        end
    end

endmodule

>>> test/tb_sorted_key_set_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_set_top
// Drives insert and remove transactions into the sorted key set: a directed
// pass over the empty, duplicate, missing and full cases and the key extremes,
// then random episodes over small key pools, under varying sender gaps and
// result back-pressure. The checker predicts and compares; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_key_set_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP       = sks_pkg::CAPACITY_DEFAULT;
    localparam int KEY_W     = sks_pkg::KEY_W;
    localparam int POOL_N    = 20;
    localparam int PHASE_OPS = 425;

    logic        clk;
    logic        rst_n;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned fail_count;
    int unsigned outstanding;

    logic signed [KEY_W-1:0] key_pool [POOL_N];

    sks_req_if req_ch ();
    sks_rsp_if rsp_ch ();

    sorted_key_set_top #(.CAPACITY(CAP)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    sks_checker #(.CAPACITY(CAP)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= stall_pct);
        end
    end

    // one request transaction, with random sender gaps ahead of it
    task automatic send_op(input sks_pkg::sks_kind_t kind,
                           input logic signed [KEY_W-1:0] k);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.kind  = kind;
        req_ch.key   = k;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    initial
    begin
        logic signed [KEY_W-1:0] k;
        logic        [KEY_W-1:0] base;
        logic        [KEY_W-1:0] step;
        int unsigned             phase_ops;
        int unsigned             run_len;
        int unsigned             insert_pct;

        req_ch.valid = 1'b0;
        req_ch.kind  = sks_pkg::KIND_INSERT;
        req_ch.key   = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pass
        send_op(sks_pkg::KIND_REMOVE, 32'sd5);
        send_op(sks_pkg::KIND_INSERT, {1'b1, {KEY_W-1{1'b0}}});
        send_op(sks_pkg::KIND_INSERT, {1'b0, {KEY_W-1{1'b1}}});
        send_op(sks_pkg::KIND_INSERT, 32'sd0);
        send_op(sks_pkg::KIND_INSERT, -32'sd1);
        send_op(sks_pkg::KIND_INSERT, 32'sd0);
        send_op(sks_pkg::KIND_REMOVE, 32'sd7);
        for (int i = 0; i < CAP - 4; i++)
            send_op(sks_pkg::KIND_INSERT, (i % 2) ? 1000 * i + 1 : -1000 * i - 3);
        send_op(sks_pkg::KIND_INSERT, 32'sd42);
        send_op(sks_pkg::KIND_INSERT, {1'b0, {KEY_W-1{1'b1}}});
        send_op(sks_pkg::KIND_REMOVE, {1'b1, {KEY_W-1{1'b0}}});

        // random episodes: a small key pool so that hits, misses and full
        // tables come up often, with a bias toward filling or draining
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 70;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 70;
                end
                default:
                begin
                    idle_pct  = 34;
                    stall_pct = 34;
                end
            endcase
            phase_ops = 0;
            while (phase_ops < PHASE_OPS)
            begin
                case ($urandom_range(3))
                    0: base = $urandom;
                    1: base = -32'sd10;
                    2: base = 32'h7FFF_FFF8;
                    default: base = 32'h8000_0000;
                endcase
                case ($urandom_range(2))
                    0: step = 1;
                    1: step = $urandom_range(1000, 1);
                    default: step = $urandom;
                endcase
                for (int i = 0; i < POOL_N; i++)
                    key_pool[i] = base + step * i;
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 20;
                endcase
                run_len = $urandom_range(60, 25);
                for (int n = 0; n < run_len; n++)
                begin
                    if ($urandom_range(9) == 0)
                        k = $urandom;
                    else
                        k = key_pool[$urandom_range(POOL_N - 1)];
                    send_op(($urandom_range(99) < insert_pct) ? sks_pkg::KIND_INSERT
                                                              : sks_pkg::KIND_REMOVE, k);
                end
                phase_ops += run_len;
            end
        end

        @(negedge clk);
        req_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
src/sks_pkg.sv
src/sks_ifs.sv
src/sorted_key_set_top.sv
test/sks_checker.sv
test/tb_sorted_key_set_top.sv
